// ----- design/mhvq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhvq_pkg
// Shared types and codes for the victim-selection max-heap.
// ----------------------------------------------------------------------------
package mhvq_pkg;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_EXTRACT = 2'd1;
    localparam logic [1:0] ACT_APPEND  = 2'd2;
    localparam logic [1:0] ACT_HEAPIFY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] block;
    } entry_t;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_UP_RD   = 12'b000000000010,
        S_UP_CMP  = 12'b000000000100,
        S_EX_RD   = 12'b000000001000,
        S_EX_LAST = 12'b000000010000,
        S_DN_RD   = 12'b000000100000,
        S_DN_RDR  = 12'b000001000000,
        S_DN_L    = 12'b000010000000,
        S_DN_CMP  = 12'b000100000000,
        S_HP_NEXT = 12'b001000000000,
        S_DN_WAIT = 12'b010000000000,
        S_OUT     = 12'b100000000000
    } state_t;

endpackage

// ----- design/max_heap_victim_queue.sv -----
// ----------------------------------------------------------------------------
// max_heap_victim_queue
// Binary max-heap of (invalid count, block) words for garbage-collection
// victim choice. Append, rejects and heapify of fewer than two entries go
// straight to the result. Insert sifts the new word up level by level;
// extract moves the last word to the root and sifts it down; heapify runs
// sift-down from each internal node, from the last one back to the root.
// One word at a time; each heap level costs one or two reads of the single
// entry RAM.
// Reset clears fill level and control; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module max_heap_victim_queue
    import mhvq_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // invalid_count[15:0], block_number[31:16]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_block, out_count, occupancy, pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);

    entry_t          mem [CAPACITY];
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    entry_t          rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t        state_reg, state_next;
    logic [PW-1:0] fill_reg, fill_next;
    logic [PW-1:0] pos_reg, pos_next;      // current heap position (1-based)
    logic [PW-1:0] hp_reg, hp_next;        // heapify start position
    logic          heapify_reg, heapify_next;
    entry_t        cur_reg, cur_next;      // entry being moved
    entry_t        lc_reg, lc_next;        // left child
    logic          ov_reg, ov_next;
    logic [1:0]    st_reg, st_next;
    entry_t        ob_reg, ob_next;

    logic [PW:0]   left_w;
    logic [PW-1:0] par_w;
    logic          has_right;
    entry_t        best_e;
    logic [PW-1:0] best_p;

    assign left_w    = {pos_reg, 1'b0};
    assign par_w     = pos_reg >> 1;
    assign has_right = (left_w + 1'b1) <= {1'b0, fill_reg};

    function automatic logic [AW-1:0] ix(input logic [PW:0] p);
        logic [PW:0] d;
        begin
            d = p - 1'b1;
            ix = d[AW-1:0];
        end
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tuser  = st_reg;
    assign m_tdata  = {5'd0, (11)'(fill_reg), ob_reg.count, ob_reg.block};

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        hp_next      = hp_reg;
        heapify_next = heapify_reg;
        cur_next     = cur_reg;
        lc_next      = lc_reg;
        ov_next      = ov_reg;
        st_next      = st_reg;
        ob_next      = ob_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = cur_reg;
        best_e       = lc_reg;
        best_p       = left_w[PW-1:0];
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    st_next  = ST_OK;
                    ob_next  = '0;
                    heapify_next = 1'b0;
                    unique case (s_tuser)
                        ACT_INSERT, ACT_APPEND:
                        begin
                            if (fill_reg >= PW'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                fill_next = fill_reg + 1'b1;
                                pos_next  = fill_reg + 1'b1;
                                cur_next  = {s_tdata[15:0], s_tdata[31:16]};
                                state_next = (s_tuser == ACT_APPEND) ? S_OUT : S_UP_RD;
                                if (s_tuser == ACT_APPEND)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = fill_reg[AW-1:0];
                                    wr_data = {s_tdata[15:0], s_tdata[31:16]};
                                end
                            end
                        end
                        ACT_EXTRACT:
                        begin
                            if (fill_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_EX_RD;
                            end
                        end
                        default:
                        begin
                            if (fill_reg < PW'(2))
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                heapify_next = 1'b1;
                                hp_next      = fill_reg >> 1;
                                pos_next     = fill_reg >> 1;
                                rd_addr      = ix({1'b0, fill_reg >> 1});
                                state_next   = S_DN_WAIT;
                            end
                        end
                    endcase
                end
            end
            // sift up: hold the new word in cur, move parents down
            S_UP_RD:
            begin
                if (pos_reg <= PW'(1))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ix({1'b0, pos_reg});
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr    = ix({1'b0, par_w});
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = ix({1'b0, pos_reg});
                if (cur_reg.count > rd_data_reg.count)
                begin
                    wr_data    = rd_data_reg;
                    pos_next   = par_w;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_EX_RD:
            begin
                ob_next    = rd_data_reg;
                rd_addr    = ix({1'b0, fill_reg});
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                cur_next  = rd_data_reg;
                fill_next = fill_reg - 1'b1;
                pos_next  = PW'(1);
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = rd_data_reg;
                state_next = S_DN_RD;
            end
            S_DN_WAIT:
            begin
                cur_next   = rd_data_reg;
                state_next = S_DN_RD;
            end
            // sift down: cur holds the sinking word, pos its slot
            S_DN_RD:
            begin
                if (left_w > {1'b0, fill_reg})
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ix({1'b0, pos_reg});
                    state_next = heapify_reg ? S_HP_NEXT : S_OUT;
                end
                else
                begin
                    rd_addr    = ix(left_w);
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                lc_next = rd_data_reg;
                rd_addr = ix(left_w + 1'b1);
                state_next = S_DN_RDR;
            end
            S_DN_RDR:
            begin
                // hold the right-child address so its word stays in the read register
                rd_addr    = ix(left_w + 1'b1);
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (has_right && rd_data_reg.count > lc_reg.count)
                begin
                    best_e = rd_data_reg;
                    best_p = left_w[PW-1:0] + 1'b1;
                end
                wr_en   = 1'b1;
                wr_addr = ix({1'b0, pos_reg});
                if (best_e.count > cur_reg.count)
                begin
                    wr_data    = best_e;
                    pos_next   = best_p;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = heapify_reg ? S_HP_NEXT : S_OUT;
                end
            end
            S_HP_NEXT:
            begin
                if (hp_reg <= PW'(1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    hp_next    = hp_reg - 1'b1;
                    pos_next   = hp_reg - 1'b1;
                    rd_addr    = ix({1'b0, hp_reg - 1'b1});
                    state_next = S_DN_WAIT;
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            ov_reg      <= 1'b0;
            heapify_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            ov_reg      <= ov_next;
            heapify_reg <= heapify_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        hp_reg  <= hp_next;
        cur_reg <= cur_next;
        lc_reg  <= lc_next;
        st_reg  <= st_next;
        ob_reg  <= ob_next;
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives heap actions into max_heap_victim_queue with random gaps on both
// sides and checks every status word against a behavioural heap kept here or a typed row.
// ----------------------------------------------------------------------------
module testbench;
    import mhvq_pkg::*;

    localparam int HEAP_DEPTH = 1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] blk;
        logic [15:0] cnt;
        logic [10:0] occ;
    } status_word_t;

    typedef struct {
        logic [1:0]   act;
        logic [15:0]  cnt;
        logic [15:0]  blk;
        bit           fixed;
        status_word_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // invalid_count[15:0], block_number[31:16]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_block[15:0], out_count[31:16], occupancy[42:32], pad
    logic [1:0]  m_tuser;   // status[1:0]

    entry_t       heap_img [1:HEAP_DEPTH];
    int           heap_fill;
    status_word_t pending_words [$];
    int           fail_count;
    bit           long_hold_req;
    stim_row_t    dir_rows [$];

    max_heap_victim_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void swap_slots(input int a, input int b);
        entry_t t;
        t = heap_img[a];
        heap_img[a] = heap_img[b];
        heap_img[b] = t;
    endfunction

    function automatic void sink_slot(input int p, input int last);
        int l;
        int best;
        while (p <= last / 2)
        begin
            l = 2 * p;
            best = p;
            if (heap_img[l].count > heap_img[best].count)
                best = l;
            if (l + 1 <= last && heap_img[l + 1].count > heap_img[best].count)
                best = l + 1;
            if (best == p)
                return;
            swap_slots(p, best);
            p = best;
        end
    endfunction

    // apply one action to the heap image and return the status word it gives
    function automatic status_word_t heap_apply(input logic [1:0] act,
                                                input logic [15:0] cnt,
                                                input logic [15:0] blk);
        status_word_t w;
        int p;
        w = '0;
        w.status = ST_OK;
        if (act == ACT_INSERT || act == ACT_APPEND)
        begin
            if (heap_fill >= HEAP_DEPTH)
                w.status = ST_FULL;
            else
            begin
                heap_fill++;
                heap_img[heap_fill] = '{count: cnt, block: blk};
                if (act == ACT_INSERT)
                begin
                    p = heap_fill;
                    while (p > 1 && heap_img[p].count > heap_img[p / 2].count)
                    begin
                        swap_slots(p, p / 2);
                        p = p / 2;
                    end
                end
            end
        end
        else if (act == ACT_EXTRACT)
        begin
            if (heap_fill == 0)
                w.status = ST_EMPTY;
            else
            begin
                w.blk = heap_img[1].block;
                w.cnt = heap_img[1].count;
                heap_img[1] = heap_img[heap_fill];
                heap_fill--;
                sink_slot(1, heap_fill);
            end
        end
        else
        begin
            for (p = heap_fill / 2; p > 0; p--)
                sink_slot(p, heap_fill);
        end
        w.occ = heap_fill[10:0];
        return w;
    endfunction

    task automatic send_word(input logic [1:0] act, input logic [15:0] cnt,
                             input logic [15:0] blk, input bit fixed,
                             input status_word_t want);
        int gap;
        status_word_t w;
        gap = $urandom_range(0, 4);
        if (($urandom & 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {blk, cnt};
        do
            @(posedge clk);
        while (!s_tready);
        w = heap_apply(act, cnt, blk);
        pending_words.push_back(fixed ? want : w);
        @(negedge clk);
    endtask

    task automatic send_random(input int p_ins, input int p_ext, input int p_app);
        int r;
        logic [1:0] act;
        r = $urandom_range(0, 99);
        if (r < p_ins)
            act = ACT_INSERT;
        else if (r < p_ins + p_ext)
            act = ACT_EXTRACT;
        else if (r < p_ins + p_ext + p_app)
            act = ACT_APPEND;
        else
            act = ACT_HEAPIFY;
        // narrow keys now and then so that ties turn up
        send_word(act, ($urandom & 1) ? 16'($urandom_range(0, 7)) : 16'($urandom),
                  16'($urandom), 1'b0, '0);
    endtask

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    // result side: random ready gaps, one long hold on request
    initial
    begin
        status_word_t got;
        status_word_t want;
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, 4);
            if (($urandom & 3) == 0)
                gap = 0;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                gap = 300;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.status = m_tuser;
            got.blk    = m_tdata[15:0];
            got.cnt    = m_tdata[31:16];
            got.occ    = m_tdata[42:32];
            if (pending_words.size() == 0)
                report("unexpected word", int'(got.status), 0);
            else
            begin
                want = pending_words.pop_front();
                if (got.status !== want.status)
                    report("status", int'(got.status), int'(want.status));
                if (got.blk !== want.blk)
                    report("out_block", int'(got.blk), int'(want.blk));
                if (got.cnt !== want.cnt)
                    report("out_count", int'(got.cnt), int'(want.cnt));
                if (got.occ !== want.occ)
                    report("occupancy", int'(got.occ), int'(want.occ));
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int i;
        int guard;
        fail_count    = 0;
        heap_fill     = 0;
        long_hold_req = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_INSERT;

        // typed rows: empty-heap errors, extremes; others from the heap image
        dir_rows = '{
            '{ACT_EXTRACT, 16'h1234, 16'h5678, 1, '{ST_EMPTY, 16'h0, 16'h0, 11'd0}},
            '{ACT_HEAPIFY, 16'h0,    16'h0,    1, '{ST_OK, 16'h0, 16'h0, 11'd0}},
            '{ACT_INSERT,  16'hFFFF, 16'hFFFF, 1, '{ST_OK, 16'h0, 16'h0, 11'd1}},
            '{ACT_HEAPIFY, 16'h0,    16'h0,    1, '{ST_OK, 16'h0, 16'h0, 11'd1}},
            '{ACT_INSERT,  16'h0,    16'h0,    1, '{ST_OK, 16'h0, 16'h0, 11'd2}},
            '{ACT_EXTRACT, 16'h0,    16'h0,    1, '{ST_OK, 16'hFFFF, 16'hFFFF, 11'd1}},
            '{ACT_EXTRACT, 16'h0,    16'h0,    1, '{ST_OK, 16'h0, 16'h0, 11'd0}},
            '{ACT_EXTRACT, 16'hFFFF, 16'hFFFF, 1, '{ST_EMPTY, 16'h0, 16'h0, 11'd0}},
            '{ACT_INSERT,  16'd5,    16'h0001, 0, '0},
            '{ACT_INSERT,  16'd5,    16'h0002, 0, '0},
            '{ACT_INSERT,  16'd5,    16'h0003, 0, '0},
            '{ACT_INSERT,  16'd9,    16'h0004, 0, '0},
            '{ACT_APPEND,  16'd1,    16'h0005, 0, '0},
            '{ACT_APPEND,  16'd20,   16'h0006, 0, '0},
            '{ACT_APPEND,  16'd20,   16'h0007, 0, '0},
            '{ACT_APPEND,  16'd3,    16'h0008, 0, '0},
            '{ACT_HEAPIFY, 16'h0,    16'h0,    0, '0},
            '{ACT_EXTRACT, 16'h0,    16'h0,    0, '0},
            '{ACT_EXTRACT, 16'h0,    16'h0,    0, '0},
            '{ACT_EXTRACT, 16'h0,    16'h0,    0, '0},
            '{ACT_APPEND,  16'hAAAA, 16'h5555, 0, '0},
            '{ACT_EXTRACT, 16'h0,    16'h0,    0, '0},
            '{ACT_EXTRACT, 16'h0,    16'h0,    0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].act, dir_rows[k].cnt, dir_rows[k].blk,
                      dir_rows[k].fixed, dir_rows[k].want);

        // mixed traffic on a small heap
        for (i = 0; i < 250; i++)
            send_random(35, 35, 25);
        drain_wait();

        // fill to capacity, block the result side part way to back up the input
        guard = 0;
        while (heap_fill < HEAP_DEPTH && guard < 3000)
        begin
            if (guard == 100)
                long_hold_req = 1'b1;
            send_random(60, 8, 31);
            guard++;
        end
        for (i = 0; i < 6; i++)
            send_word(i[0] ? ACT_APPEND : ACT_INSERT, 16'($urandom), 16'($urandom),
                      1'b0, '0);
        send_word(ACT_HEAPIFY, 16'h0, 16'h0, 1'b0, '0);
        drain_wait();

        // drain part of the way, mostly extracts on a deep heap
        guard = 0;
        while (heap_fill > 0 && guard < 400)
        begin
            send_random(15, 80, 4);
            guard++;
        end
        for (i = 0; i < 4; i++)
            send_word(ACT_EXTRACT, 16'($urandom), 16'($urandom), 1'b0, '0);

        drain_wait();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/mhvq_pkg.sv
design/max_heap_victim_queue.sv
dv/testbench.sv
